// ===== hdl/cxc_pkg.sv =====
package cxc_pkg;

  // Field and datapath widths.
  localparam int NUM_CHAN  = 4;
  localparam int NUM_SRC   = 3;
  localparam int CHAN_W    = 16;
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int PROD_W    = COEF_W + CHAN_W + 1;
  localparam int ACC_W     = PROD_W + 1;
  localparam int COR_W     = 20;
  localparam int PUR_W     = 17;
  localparam int CFG_W     = NUM_SRC * COEF_W;
  localparam int CFG_IDX_W = 3;

  // Chastity divider: one entry stage, then iteration stages of four quotient bits each.
  localparam int DIV_BITS   = 4;
  localparam int DIV_ITERS  = (PUR_W - 1) / DIV_BITS;
  localparam int DIV_STAGES = DIV_ITERS + 1;

  localparam logic [PUR_W-1:0] PURITY_ONE = PUR_W'(1) << (PUR_W - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd5;

  // Chastity special-case codes.
  localparam logic [1:0] PUR_NORMAL = 2'd0;
  localparam logic [1:0] PUR_ZERO   = 2'd1;
  localparam logic [1:0] PUR_ONE    = 2'd2;

  typedef logic [NUM_CHAN-1:0][COR_W-1:0] cor_vec_t;

  // Side data that rides along with an item through the divider.
  typedef struct packed {
    cor_vec_t   cor;
    logic [1:0] best;
  } cxc_tag_t;

  // Source channel of the k-th coefficient in the row of channel r.
  function automatic logic [1:0] src_idx(input logic [1:0] r, input logic [1:0] k);
    logic [1:0] j;
    j = (k < r) ? k : k + 2'd1;
    return j;
  endfunction

endpackage

// ===== hdl/crosstalk_correct_chastity_unit.sv =====
// Four-channel crosstalk correction with chastity.
// Nine register stages lie between item acceptance and out_valid
// (multiply, sum, rank, five divider stages, output register).
// Throughput: one item per cycle; every stage stalls independently on back-pressure.
// Reset (synchronous, rst_n low): pipeline empties, coefficients clear to 0,
// clamp is enabled and the chastity threshold clears to 0.
module crosstalk_correct_chastity_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cxc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cxc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cxc_pkg::CHAN_W-1:0]          in_chan_one_in,
  input  logic [cxc_pkg::CHAN_W-1:0]          in_chan_two_in,
  input  logic [cxc_pkg::CHAN_W-1:0]          in_chan_three_in,
  input  logic [cxc_pkg::CHAN_W-1:0]          in_chan_four_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cxc_pkg::COR_W-1:0]    out_chan_one_out,
  output logic signed [cxc_pkg::COR_W-1:0]    out_chan_two_out,
  output logic signed [cxc_pkg::COR_W-1:0]    out_chan_three_out,
  output logic signed [cxc_pkg::COR_W-1:0]    out_chan_four_out,
  output logic [1:0]                          out_brightest,
  output logic [cxc_pkg::PUR_W-1:0]           out_purity,
  output logic                                out_passes
);

  localparam int NC = cxc_pkg::NUM_CHAN;
  localparam int NK = cxc_pkg::NUM_SRC;
  localparam int CW = cxc_pkg::COEF_W;
  localparam int PW = cxc_pkg::PROD_W;
  localparam int AW = cxc_pkg::ACC_W;
  localparam int RW = cxc_pkg::COR_W;
  localparam int FB = cxc_pkg::FRAC_BITS;

  // Configuration registers.
  logic [cxc_pkg::CFG_W-1:0] coef_r [NC];
  logic                      clamp_r;
  logic [cxc_pkg::PUR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NC; r++) begin
        coef_r[r] <= '0;
      end
      clamp_r <= 1'b1;
      thr_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cxc_pkg::REG_COEF_ONE:   coef_r[0] <= cfg_data;
        cxc_pkg::REG_COEF_TWO:   coef_r[1] <= cfg_data;
        cxc_pkg::REG_COEF_THREE: coef_r[2] <= cfg_data;
        cxc_pkg::REG_COEF_FOUR:  coef_r[3] <= cfg_data;
        cxc_pkg::REG_CLAMP:      clamp_r   <= cfg_data[0];
        cxc_pkg::REG_THRESHOLD:  thr_r     <= cfg_data[cxc_pkg::PUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake chain between stages.
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_o;
  logic div_in_ready, div_out_valid;

  assign rdy_o    = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || div_in_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r        <= in_valid;
      if (rdy2)  v2_r        <= v1_r;
      if (rdy3)  v3_r        <= v2_r;
      if (rdy_o) out_valid_r <= div_out_valid;
    end
  end

  // Stage 1: the twelve crosstalk products.
  logic [NC-1:0][cxc_pkg::CHAN_W-1:0] raw;
  logic [NC-1:0][cxc_pkg::CHAN_W-1:0] raw1_r;
  logic signed [PW-1:0] prod_nxt [NC][NK];
  logic signed [PW-1:0] prod1_r  [NC][NK];

  assign raw = {in_chan_four_in, in_chan_three_in, in_chan_two_in, in_chan_one_in};

  always_comb begin
    logic [1:0] j;
    for (int r = 0; r < NC; r++) begin
      for (int k = 0; k < NK; k++) begin
        j = cxc_pkg::src_idx(2'(r), 2'(k));
        prod_nxt[r][k] = $signed(coef_r[r][k*CW +: CW]) * $signed({1'b0, raw[j]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      raw1_r  <= raw;
      prod1_r <= prod_nxt;
    end
  end

  // Stage 2: subtract the leakage, clamp negatives when enabled, truncate toward zero.
  cxc_pkg::cor_vec_t cor_nxt;
  cxc_pkg::cor_vec_t cor2_r;

  always_comb begin
    logic signed [AW-1:0] acc;
    for (int r = 0; r < NC; r++) begin
      acc = $signed({{(AW-cxc_pkg::CHAN_W-FB){1'b0}}, raw1_r[r], {FB{1'b0}}});
      for (int k = 0; k < NK; k++) begin
        acc = acc - AW'(prod1_r[r][k]);
      end
      if (clamp_r && acc < 0) begin
        acc = '0;
      end
      if (acc < 0) begin
        acc = acc + AW'((1 << FB) - 1);
      end
      cor_nxt[r] = acc[FB +: RW];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      cor2_r <= cor_nxt;
    end
  end

  // Stage 3: brightest channel and second-largest value by a small tournament.
  cxc_pkg::cxc_tag_t     tag_nxt, tag3_r;
  logic signed [RW-1:0]  maxv_nxt, second_nxt, maxv3_r, second3_r;

  always_comb begin
    logic signed [RW-1:0] c0, c1, c2, c3;
    logic signed [RW-1:0] w01, l01, w23, l23, lf, lp;
    logic [1:0]           i01, i23;
    c0 = cor2_r[0];
    c1 = cor2_r[1];
    c2 = cor2_r[2];
    c3 = cor2_r[3];
    if (c1 > c0) begin
      i01 = 2'd1; w01 = c1; l01 = c0;
    end else begin
      i01 = 2'd0; w01 = c0; l01 = c1;
    end
    if (c3 > c2) begin
      i23 = 2'd3; w23 = c3; l23 = c2;
    end else begin
      i23 = 2'd2; w23 = c2; l23 = c3;
    end
    if (w23 > w01) begin
      tag_nxt.best = i23; maxv_nxt = w23; lf = w01; lp = l23;
    end else begin
      tag_nxt.best = i01; maxv_nxt = w01; lf = w23; lp = l01;
    end
    second_nxt  = (lp > lf) ? lp : lf;
    tag_nxt.cor = cor2_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      tag3_r    <= tag_nxt;
      maxv3_r   <= maxv_nxt;
      second3_r <= second_nxt;
    end
  end

  // Stages 4 to 8: chastity division.
  logic [cxc_pkg::PUR_W-1:0] div_purity;
  cxc_pkg::cxc_tag_t         div_tag;

  cxc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v3_r),
    .in_ready   (div_in_ready),
    .in_maxv    (maxv3_r),
    .in_second  (second3_r),
    .in_tag     (tag3_r),
    .out_valid  (div_out_valid),
    .out_ready  (rdy_o),
    .out_purity (div_purity),
    .out_tag    (div_tag)
  );

  // Output register with the threshold compare.
  cxc_pkg::cor_vec_t         cor_o_r;
  logic [1:0]                best_o_r;
  logic [cxc_pkg::PUR_W-1:0] pur_o_r;
  logic                      pass_o_r;

  always_ff @(posedge clk) begin
    if (rdy_o && div_out_valid) begin
      cor_o_r  <= div_tag.cor;
      best_o_r <= div_tag.best;
      pur_o_r  <= div_purity;
      pass_o_r <= (div_purity >= thr_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chan_one_out   = cor_o_r[0];
  assign out_chan_two_out   = cor_o_r[1];
  assign out_chan_three_out = cor_o_r[2];
  assign out_chan_four_out  = cor_o_r[3];
  assign out_brightest      = best_o_r;
  assign out_purity         = pur_o_r;
  assign out_passes         = pass_o_r;

`ifndef ASSERT_OFF
  // A nonzero chastity lies between one half and one.
  a_purity_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && pur_o_r != '0 |->
      pur_o_r >= (cxc_pkg::PURITY_ONE >> 1) && pur_o_r <= cxc_pkg::PURITY_ONE)
    else $error("chastity outside its range");

  // Channel one reported brightest is at least every other channel.
  a_best_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && best_o_r == 2'd0 |->
      $signed(cor_o_r[0]) >= $signed(cor_o_r[1]) &&
      $signed(cor_o_r[0]) >= $signed(cor_o_r[2]) &&
      $signed(cor_o_r[0]) >= $signed(cor_o_r[3]))
    else $error("brightest channel one is not a maximum");

  // Channel four wins only when strictly above all others.
  a_best_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && best_o_r == 2'd3 |->
      $signed(cor_o_r[3]) > $signed(cor_o_r[0]) &&
      $signed(cor_o_r[3]) > $signed(cor_o_r[1]) &&
      $signed(cor_o_r[3]) > $signed(cor_o_r[2]))
    else $error("brightest channel four breaks the lowest-index tie rule");
`endif

endmodule

// ===== hdl/cxc_div.sv =====
module cxc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [cxc_pkg::COR_W-1:0] in_maxv,
  input  logic signed [cxc_pkg::COR_W-1:0] in_second,
  input  cxc_pkg::cxc_tag_t             in_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cxc_pkg::PUR_W-1:0]     out_purity,
  output cxc_pkg::cxc_tag_t             out_tag
);

  localparam int NS = cxc_pkg::DIV_STAGES;
  localparam int RW = cxc_pkg::COR_W;
  localparam int QW = cxc_pkg::PUR_W;

  logic [NS-1:0]     v_r;
  logic [NS-1:0]     rdy;
  logic [NS-1:0]     vin;
  logic [RW-1:0]     rem_r  [NS];
  logic [RW-1:0]     den_r  [NS];
  logic [QW-1:0]     q_r    [NS];
  logic [1:0]        code_r [NS];
  cxc_pkg::cxc_tag_t tag_r  [NS];
  logic [RW-1:0]     rem_nxt  [NS];
  logic [RW-1:0]     den_nxt  [NS];
  logic [QW-1:0]     q_nxt    [NS];
  logic [1:0]        code_nxt [NS];
  cxc_pkg::cxc_tag_t tag_nxt  [NS];

  // Per-stage ready: a stage takes an item when empty or when it moves on.
  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    vin[0] = in_valid;
    for (int k = 1; k < NS; k++) begin
      vin[k] = v_r[k-1];
    end
  end

  assign in_ready = rdy[0];

  // Entry stage: denominator, special cases and the integer quotient bit.
  // Iteration stages: restoring division, four quotient bits per stage.
  always_comb begin
    logic signed [RW:0] den_s;
    logic [RW-1:0]      m;
    logic [RW-1:0]      d;
    logic               qtop;
    logic [RW-1:0]      r;
    logic [RW:0]        r2;
    logic [QW-1:0]      q;
    logic               qb;
    den_s = (RW+1)'(in_maxv) + (RW+1)'(in_second);
    m     = in_maxv;
    d     = den_s[RW-1:0];
    qtop  = (m >= d);
    if (den_s <= 0) begin
      code_nxt[0] = cxc_pkg::PUR_ZERO;
    end else if (in_second < 0) begin
      code_nxt[0] = cxc_pkg::PUR_ONE;
    end else begin
      code_nxt[0] = cxc_pkg::PUR_NORMAL;
    end
    den_nxt[0] = d;
    rem_nxt[0] = qtop ? (m - d) : m;
    q_nxt[0]   = {qtop, {(QW-1){1'b0}}};
    tag_nxt[0] = in_tag;

    for (int k = 1; k < NS; k++) begin
      r = rem_r[k-1];
      q = q_r[k-1];
      for (int b = 0; b < cxc_pkg::DIV_BITS; b++) begin
        r2 = {r, 1'b0};
        qb = (r2 >= {1'b0, den_r[k-1]});
        if (qb) begin
          r2 = r2 - {1'b0, den_r[k-1]};
        end
        r = r2[RW-1:0];
        q[QW - 2 - (k - 1) * cxc_pkg::DIV_BITS - b] = qb;
      end
      rem_nxt[k]  = r;
      q_nxt[k]    = q;
      den_nxt[k]  = den_r[k-1];
      code_nxt[k] = code_r[k-1];
      tag_nxt[k]  = tag_r[k-1];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vin[k];
        end
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k] && vin[k]) begin
        rem_r[k]  <= rem_nxt[k];
        den_r[k]  <= den_nxt[k];
        q_r[k]    <= q_nxt[k];
        code_r[k] <= code_nxt[k];
        tag_r[k]  <= tag_nxt[k];
      end
    end
  end

  // Final chastity with the special cases applied.
  always_comb begin
    case (code_r[NS-1])
      cxc_pkg::PUR_ZERO: out_purity = '0;
      cxc_pkg::PUR_ONE:  out_purity = cxc_pkg::PURITY_ONE;
      default:           out_purity = q_r[NS-1];
    endcase
  end

  assign out_valid = v_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

// ===== tb/tb_crosstalk_correct_chastity_unit.sv =====
`timescale 1ns / 100ps

module tb_crosstalk_correct_chastity_unit;

  localparam int NUM_CHAN  = cxc_pkg::NUM_CHAN;
  localparam int CHAN_W    = cxc_pkg::CHAN_W;
  localparam int COEF_W    = cxc_pkg::COEF_W;
  localparam int COR_W     = cxc_pkg::COR_W;
  localparam int PUR_W     = cxc_pkg::PUR_W;
  localparam int CFG_W     = cxc_pkg::CFG_W;
  localparam int CFG_IDX_W = cxc_pkg::CFG_IDX_W;
  localparam int FRAC_BITS = cxc_pkg::FRAC_BITS;
  localparam logic [PUR_W-1:0] PURITY_ONE = cxc_pkg::PURITY_ONE;

  localparam int CLK_HALF    = 5;
  localparam int RESET_LEN   = 12;
  localparam int SETTLE      = 12;
  localparam int HOLD_CYCLES = 90;
  localparam int LIMIT       = 300000;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Q2.14 coefficient codes used by the directed checks.
  localparam logic [COEF_W-1:0] LEAK_NONE    = 16'h0000;
  localparam logic [COEF_W-1:0] LEAK_HALF    = 16'h2000;
  localparam logic [COEF_W-1:0] LEAK_UNITY   = 16'h4000;
  localparam logic [COEF_W-1:0] LEAK_POS_MAX = 16'h7FFF;
  localparam logic [COEF_W-1:0] LEAK_NEG_MAX = 16'h8000;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] cluster_t;

  typedef struct packed {
    cxc_pkg::cor_vec_t cor;
    logic [1:0]        best;
    logic [PUR_W-1:0]  purity;
    logic              passes;
  } cluster_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]             cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic [CHAN_W-1:0]            in_chan_one_in;
  logic [CHAN_W-1:0]            in_chan_two_in;
  logic [CHAN_W-1:0]            in_chan_three_in;
  logic [CHAN_W-1:0]            in_chan_four_in;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [COR_W-1:0]      out_chan_one_out;
  logic signed [COR_W-1:0]      out_chan_two_out;
  logic signed [COR_W-1:0]      out_chan_three_out;
  logic signed [COR_W-1:0]      out_chan_four_out;
  logic [1:0]                   out_brightest;
  logic [PUR_W-1:0]             out_purity;
  logic                         out_passes;

  // Shadow copy of the block's registers.
  logic [CFG_W-1:0]             leak_coef [NUM_CHAN];
  logic                         clamp_neg;
  logic [PUR_W-1:0]             pass_floor;

  cluster_result_t              expected_q [$];
  cluster_result_t              head_want;

  int   cycle_count   = 0;
  int   items_sent    = 0;
  int   results_seen  = 0;
  int   mismatches    = 0;
  int   cfg_writes    = 0;
  int   hold_asked    = 0;
  int   hold_taken    = 0;
  int   hold_left     = 0;
  int   stall_left    = 0;
  bit   steady        = 1'b0;

  crosstalk_correct_chastity_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_chan_one_in     (in_chan_one_in),
    .in_chan_two_in     (in_chan_two_in),
    .in_chan_three_in   (in_chan_three_in),
    .in_chan_four_in    (in_chan_four_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_chan_one_out   (out_chan_one_out),
    .out_chan_two_out   (out_chan_two_out),
    .out_chan_three_out (out_chan_three_out),
    .out_chan_four_out  (out_chan_four_out),
    .out_brightest      (out_brightest),
    .out_purity         (out_purity),
    .out_passes         (out_passes)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog for a hung handshake.
  initial begin
    while (cycle_count < LIMIT) @(posedge clk);
    $display("tb_crosstalk_correct_chastity_unit failed");
    $finish;
  end

  // Corrected channels, brightest channel and chastity for one cluster.
  function automatic cluster_result_t predict_cluster(input cluster_t raw);
    cluster_result_t res;
    longint          acc;
    longint          cor [NUM_CHAN];
    longint          maxv;
    longint          second;
    longint          den;
    longint          pur;
    logic [COEF_W-1:0] cf;
    int              k;
    int              best;
    bit              have;
    for (int r = 0; r < NUM_CHAN; r++) begin
      acc = longint'(raw[r]) <<< FRAC_BITS;
      k = 0;
      for (int j = 0; j < NUM_CHAN; j++) begin
        if (j != r) begin
          cf = leak_coef[r][COEF_W*k +: COEF_W];
          acc = acc - longint'(signed'(cf)) * longint'(raw[j]);
          k++;
        end
      end
      if (clamp_neg && acc < 0) acc = 0;
      // Drop the fraction toward zero.
      cor[r] = (acc >= 0) ? (acc >>> FRAC_BITS) : -((-acc) >>> FRAC_BITS);
      res.cor[r] = cor[r][COR_W-1:0];
    end
    best = 0;
    for (int r = 1; r < NUM_CHAN; r++) begin
      if (cor[r] > cor[best]) best = r;
    end
    maxv = cor[best];
    second = 0;
    have = 1'b0;
    for (int r = 0; r < NUM_CHAN; r++) begin
      if (r != best && (!have || cor[r] > second)) begin
        second = cor[r];
        have = 1'b1;
      end
    end
    // Chastity: zero for a non-positive sum, full when the runner-up is negative.
    den = maxv + second;
    if (den <= 0) pur = 0;
    else if (second < 0) pur = longint'(PURITY_ONE);
    else begin
      pur = (maxv * longint'(PURITY_ONE)) / den;
      if (pur > longint'(PURITY_ONE)) pur = longint'(PURITY_ONE);
    end
    res.best = best[1:0];
    res.purity = pur[PUR_W-1:0];
    res.passes = (pur >= longint'(pass_floor));
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d field %s got %0d expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
      end else begin
        head_want = expected_q.pop_front();
        check_field("chan_one", out_chan_one_out, $signed(head_want.cor[0]));
        check_field("chan_two", out_chan_two_out, $signed(head_want.cor[1]));
        check_field("chan_three", out_chan_three_out, $signed(head_want.cor[2]));
        check_field("chan_four", out_chan_four_out, $signed(head_want.cor[3]));
        check_field("brightest", out_brightest, head_want.best);
        check_field("purity", out_purity, head_want.purity);
        check_field("passes", out_passes, head_want.passes);
        results_seen++;
      end
    end
  end

  // Result receiver: random stall bursts, a long hold on request, none when steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offers one cluster, at times with a random gap ahead of it unless steady, and records its prediction.
  task automatic send_cluster(input cluster_t raw);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_chan_one_in <= raw[0];
    in_chan_two_in <= raw[1];
    in_chan_three_in <= raw[2];
    in_chan_four_in <= raw[3];
    do @(posedge clk); while (!in_ready);
    expected_q.insert(expected_q.size(), predict_cluster(raw));
    items_sent++;
  endtask

  // Stops offering and waits until every outstanding result has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx <= cxc_pkg::REG_COEF_FOUR) leak_coef[idx[1:0]] = data;
    else if (idx == cxc_pkg::REG_CLAMP) clamp_neg = data[0];
    else if (idx == cxc_pkg::REG_THRESHOLD) pass_floor = data[PUR_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic write_all_rows(input logic [COEF_W-1:0] leak);
    write_reg(cxc_pkg::REG_COEF_ONE, {3{leak}});
    write_reg(cxc_pkg::REG_COEF_TWO, {3{leak}});
    write_reg(cxc_pkg::REG_COEF_THREE, {3{leak}});
    write_reg(cxc_pkg::REG_COEF_FOUR, {3{leak}});
  endtask

  function automatic logic [COEF_W-1:0] random_leak();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick inside {[0:4]}) begin
      return COEF_W'($urandom_range(0, 3000));
    end else if (pick inside {[5:6]}) begin
      return COEF_W'(0 - int'($urandom_range(0, 3000)));
    end
    case (pick)
      7:       return LEAK_POS_MAX;
      8:       return LEAK_NEG_MAX;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [PUR_W-1:0] random_floor();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return PURITY_ONE;
      2:       return PUR_W'($urandom_range(65537, 131071));
      default: return PUR_W'($urandom_range(20000, 65536));
    endcase
  endfunction

  // Mostly bright clusters with one dominant dye, plus full-range and edge values.
  function automatic cluster_t random_cluster();
    cluster_t raw;
    int       lead;
    int       top;
    lead = $urandom_range(0, NUM_CHAN - 1);
    top = $urandom_range(8000, 65535);
    for (int r = 0; r < NUM_CHAN; r++) begin
      case ($urandom_range(0, 3))
        0: raw[r] = CHAN_W'($urandom);
        1: raw[r] = (r == lead) ? CHAN_W'(top) : CHAN_W'($urandom_range(0, top / 6));
        2: raw[r] = CHAN_W'($urandom_range(0, 255));
        default: begin
          case ($urandom_range(0, 3))
            0:       raw[r] = '0;
            1:       raw[r] = 16'd1;
            2:       raw[r] = 16'h8000;
            default: raw[r] = 16'hFFFF;
          endcase
        end
      endcase
    end
    // Half the time keep the whole cluster in the dominant-dye shape.
    if ($urandom_range(0, 1) == 0) begin
      for (int r = 0; r < NUM_CHAN; r++) begin
        raw[r] = (r == lead) ? CHAN_W'(top) : CHAN_W'($urandom_range(0, top / 6));
      end
    end
    return raw;
  endfunction

  task automatic load_random_setup();
    logic [CFG_W-1:0] junk;
    for (int r = 0; r < NUM_CHAN; r++) begin
      write_reg(cxc_pkg::REG_COEF_ONE + CFG_IDX_W'(r),
                {random_leak(), random_leak(), random_leak()});
    end
    junk = {16'($urandom), 32'($urandom)};
    write_reg(cxc_pkg::REG_CLAMP, junk);
    junk = {16'($urandom), 32'($urandom)};
    write_reg(cxc_pkg::REG_THRESHOLD, {junk[CFG_W-1:PUR_W], random_floor()});
  endtask

  // Reset values: no leakage, clamp on, zero threshold; ties and empty clusters.
  task automatic test_reset_state();
    send_cluster({16'd0, 16'd0, 16'd0, 16'd0});
    send_cluster({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_cluster({16'hFFFF, 16'd0, 16'd0, 16'd0});
    send_cluster({16'd5, 16'd300, 16'd300, 16'd100});
    send_cluster({16'd0, 16'd0, 16'd0, 16'd1});
    drain();
  endtask

  // Extreme coefficients, unclamped negatives, zero and full chastity, threshold edges.
  task automatic test_corner_configs();
    // Extreme leakage in rows two to four, none in row one: channels two and three go far negative.
    write_reg(cxc_pkg::REG_COEF_ONE, {3{LEAK_NONE}});
    write_reg(cxc_pkg::REG_COEF_TWO, {3{LEAK_POS_MAX}});
    write_reg(cxc_pkg::REG_COEF_THREE, {3{LEAK_POS_MAX}});
    write_reg(cxc_pkg::REG_COEF_FOUR, {LEAK_NEG_MAX, LEAK_POS_MAX, LEAK_NEG_MAX});
    write_reg(cxc_pkg::REG_CLAMP, '0);
    write_reg(cxc_pkg::REG_THRESHOLD, CFG_W'(PURITY_ONE));
    send_cluster({16'd0, 16'd0, 16'd0, 16'hFFFF});
    send_cluster({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_cluster({16'hFFFF, 16'd0, 16'hFFFF, 16'd0});
    drain();
    // Unity leakage: a lone channel leaves a sum of zero, and below zero.
    write_all_rows(LEAK_UNITY);
    send_cluster({16'd0, 16'd0, 16'd0, 16'd100});
    send_cluster({16'd0, 16'd50, 16'd100, 16'd500});
    send_cluster({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    drain();
    // Half leakage: fractional negatives truncate toward zero.
    write_all_rows(LEAK_HALF);
    send_cluster({16'd1, 16'd1, 16'd1, 16'd0});
    send_cluster({16'd3, 16'd0, 16'd7, 16'd1});
    drain();
    // Threshold above one never passes; clamp back on.
    write_all_rows(LEAK_NONE);
    write_reg(cxc_pkg::REG_CLAMP, CFG_W'(1));
    write_reg(cxc_pkg::REG_THRESHOLD, CFG_W'(PURITY_ONE) + 1);
    send_cluster({16'hFFFF, 16'd0, 16'd0, 16'd0});
    drain();
    write_reg(cxc_pkg::REG_THRESHOLD, {{(CFG_W - PUR_W){1'b0}}, {PUR_W{1'b1}}});
    send_cluster({16'd0, 16'd0, 16'd9, 16'd0});
    drain();
    // Clamped negatives with a reversed leak.
    write_all_rows(LEAK_POS_MAX);
    send_cluster({16'd1000, 16'hFFFF, 16'd20, 16'd0});
    drain();
  endtask

  // Spare indexes are ignored and writes keep only the register width.
  task automatic test_register_writes();
    write_reg(cxc_pkg::REG_COEF_ONE, {LEAK_HALF, LEAK_NEG_MAX, 16'h0123});
    write_reg(cxc_pkg::REG_COEF_TWO, {16'hF000, LEAK_UNITY, 16'h0800});
    write_reg(cxc_pkg::REG_COEF_THREE, {16'h0400, 16'hFC00, LEAK_POS_MAX});
    write_reg(cxc_pkg::REG_COEF_FOUR, {16'h1000, 16'h1000, 16'h1000});
    write_reg(cxc_pkg::REG_CLAMP, 48'hFFFF_FFFF_FFFE);
    write_reg(cxc_pkg::REG_THRESHOLD, 48'hABCD_1235_8000);
    write_reg(REG_SPARE_LO, {CFG_W{1'b1}});
    write_reg(REG_SPARE_HI, 48'h5A5A_A5A5_0F0F);
    send_cluster({16'd1234, 16'd40000, 16'd900, 16'd65535});
    send_cluster({16'd60000, 16'd100, 16'd2000, 16'd7});
    send_cluster({16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
    send_cluster({16'd333, 16'd32768, 16'd32767, 16'd1});
    drain();
  endtask

  task automatic test_random_clusters();
    for (int phase = 0; phase < 8; phase++) begin
      load_random_setup();
      repeat (75) send_cluster(random_cluster());
      drain();
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_stall();
    hold_asked++;
    repeat (40) send_cluster(random_cluster());
    drain();
  endtask

  task automatic test_back_to_back();
    load_random_setup();
    steady = 1'b1;
    repeat (50) send_cluster(random_cluster());
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= cxc_pkg::REG_COEF_ONE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_chan_one_in <= '0;
    in_chan_two_in <= '0;
    in_chan_three_in <= '0;
    in_chan_four_in <= '0;
    for (int r = 0; r < NUM_CHAN; r++) leak_coef[r] = '0;
    clamp_neg = 1'b1;
    pass_floor = '0;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_corner_configs();
    test_register_writes();
    test_random_clusters();
    test_output_stall();
    test_back_to_back();

    $display("Sent %0d clusters across %0d register writes; %0d results compared, %0d bad.",
             items_sent, cfg_writes, results_seen, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_crosstalk_correct_chastity_unit passed");
    end else begin
      $display("tb_crosstalk_correct_chastity_unit failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cxc_pkg.sv
hdl/cxc_div.sv
hdl/crosstalk_correct_chastity_unit.sv
tb/tb_crosstalk_correct_chastity_unit.sv
